### design/cxsr_pkg.sv
// cxsr_pkg: shared constants, widths and control structs of the combined xor-shift generator
// no dependencies; used by every module of the block
package cxsr_pkg;

    // table geometry and batch length
    localparam int LONG_LEN   = 9689;
    localparam int LONG_TAP   = 471;
    localparam int SHORT_LEN  = 127;
    localparam int SHORT_TAP  = 30;
    localparam int BATCH_SIZE = 10000;

    localparam int LONG_AW  = $clog2(LONG_LEN);
    localparam int SHORT_AW = $clog2(SHORT_LEN);
    localparam int FILL_AW  = (LONG_AW > SHORT_AW) ? LONG_AW : SHORT_AW;
    localparam int BATCH_W  = $clog2(BATCH_SIZE + 1);

    // tap pointers after reset or refill (zero-based, head sits at zero)
    localparam int LONG_TAP_RST  = LONG_TAP % LONG_LEN;
    localparam int SHORT_TAP_RST = SHORT_TAP % SHORT_LEN;

    // seeding sequence constants
    localparam int unsigned MULT_INIT    = 387420489;
    localparam int unsigned SEED_MULT    = 1313131;
    localparam int unsigned MULT_STEP    = 32781;
    localparam int unsigned MOD_STEP     = 125;
    localparam int unsigned LONG_FACTOR  = 8193;
    localparam int unsigned SHORT_FACTOR = 4099;

    // truncating remainder by a constant divisor, via reciprocal and one correction
    localparam int          MOD_DIV   = 2796203;
    localparam longint      MOD_RECIP = 64'd4294967296 / MOD_DIV;
    localparam int          RECIP_W   = $clog2(MOD_RECIP + 1);
    localparam int          REM_W     = $clog2(MOD_DIV);
    localparam int          R_W       = REM_W + 1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic seed_prep;     // capture seed magnitude plus one
        logic seed_load;     // start multiplicative sequence, form seed product
        logic rem_from_seed; // remainder unit takes the seed product
        logic m_step;        // advance multiplicative sequence
        logic r_load;        // take remainder unit result
        logic fill_start;    // restart fill index and table pointers
        logic fill_wr;       // write one seeding word
        logic adv_wr;        // write back both tables and advance pointers
        logic out_load;      // capture the generated word for output
    } cxsr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic fill_last;     // fill index on the final short-table entry
    } cxsr_status_t;

endpackage

### design/cxsr_rem.sv
// cxsr_rem: three-stage truncating remainder by the constant divisor
// depends on cxsr_pkg for divisor, reciprocal and widths
module cxsr_rem (
    input  logic                              aclk,
    input  logic [31:0]                       x_in,    // two's complement dividend
    output logic signed [cxsr_pkg::R_W-1:0]   rem_out  // signed remainder of x_in
);

    localparam int PW = 32 + cxsr_pkg::RECIP_W;

    logic [31:0]                    mag1_reg;
    logic                           neg1_reg;
    logic [cxsr_pkg::RECIP_W-1:0]   q2_reg;
    logic [31:0]                    mag2_reg;
    logic                           neg2_reg;
    logic [cxsr_pkg::REM_W:0]       raw3_reg;
    logic                           neg3_reg;

    logic [PW-1:0]                  prod_w;
    logic [31:0]                    qd_w;
    logic [31:0]                    diff_w;
    logic [cxsr_pkg::REM_W:0]       corr_w;
    logic [cxsr_pkg::REM_W-1:0]     rem_w;

    // quotient estimate, at most one short
    assign prod_w = PW'(mag1_reg) * PW'(cxsr_pkg::MOD_RECIP);
    assign qd_w   = 32'(q2_reg) * 32'(cxsr_pkg::MOD_DIV);
    assign diff_w = mag2_reg - qd_w;

    // stage registers: magnitude, quotient, raw remainder
    always_ff @(posedge aclk) begin
        neg1_reg <= x_in[31];
        mag1_reg <= x_in[31] ? (32'd0 - x_in) : x_in;
        q2_reg   <= prod_w[PW-1:32];
        mag2_reg <= mag1_reg;
        neg2_reg <= neg1_reg;
        raw3_reg <= diff_w[cxsr_pkg::REM_W:0];
        neg3_reg <= neg2_reg;
    end

    // final correction and sign of the dividend
    assign corr_w  = (raw3_reg >= (cxsr_pkg::REM_W + 1)'(cxsr_pkg::MOD_DIV))
                   ? raw3_reg - (cxsr_pkg::REM_W + 1)'(cxsr_pkg::MOD_DIV) : raw3_reg;
    assign rem_w   = corr_w[cxsr_pkg::REM_W-1:0];
    assign rem_out = neg3_reg ? -$signed({1'b0, rem_w}) : $signed({1'b0, rem_w});

endmodule

### design/cxsr_dp.sv
// cxsr_dp: seed register, seeding sequences, both tables, pointers and output word
// depends on cxsr_pkg and cxsr_rem
module cxsr_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  cxsr_pkg::cxsr_cmd_t    cmd,
    output cxsr_pkg::cxsr_status_t status,
    output logic [31:0]            out_data
);

    logic [31:0]                   seed_reg;
    logic [31:0]                   iseed_reg;
    logic [31:0]                   prod_reg;
    logic [31:0]                   m_reg;
    logic signed [cxsr_pkg::R_W-1:0] r_reg;
    logic [31:0]                   out_reg;

    logic [cxsr_pkg::FILL_AW-1:0]  fill_idx_reg;
    logic                          fill_short_reg;

    logic [cxsr_pkg::LONG_AW-1:0]  long_head_reg;
    logic [cxsr_pkg::LONG_AW-1:0]  long_tap_reg;
    logic [cxsr_pkg::SHORT_AW-1:0] short_head_reg;
    logic [cxsr_pkg::SHORT_AW-1:0] short_tap_reg;

    logic [31:0] long_mem  [cxsr_pkg::LONG_LEN];
    logic [31:0] short_mem [cxsr_pkg::SHORT_LEN];
    logic [31:0] long_rd_a_reg;
    logic [31:0] long_rd_b_reg;
    logic [31:0] short_rd_a_reg;
    logic [31:0] short_rd_b_reg;

    logic [31:0]                   seed_mag_w;
    logic [31:0]                   r_ext_w;
    logic [31:0]                   rem_x_w;
    logic signed [cxsr_pkg::R_W-1:0] rem_w;
    logic [31:0]                   fill_word_w;
    logic [31:0]                   long_new_w;
    logic [31:0]                   short_new_w;
    logic                          long_we_w;
    logic                          short_we_w;
    logic [cxsr_pkg::LONG_AW-1:0]  long_waddr_w;
    logic [cxsr_pkg::SHORT_AW-1:0] short_waddr_w;
    logic [31:0]                   long_wdata_w;
    logic [31:0]                   short_wdata_w;

    // seed magnitude and sign-extended remainder state
    assign seed_mag_w = seed_reg[31] ? (32'd0 - seed_reg) : seed_reg;
    assign r_ext_w    = 32'(r_reg);
    assign rem_x_w    = cmd.rem_from_seed ? prod_reg : r_ext_w * cxsr_pkg::MOD_STEP;

    cxsr_rem u_rem (
        .aclk    (aclk),
        .x_in    (rem_x_w),
        .rem_out (rem_w)
    );

    // seeding word for the table being filled
    assign fill_word_w = m_reg + r_ext_w *
                         (fill_short_reg ? cxsr_pkg::SHORT_FACTOR : cxsr_pkg::LONG_FACTOR);

    // seed register and seeding sequences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_prep) begin
            iseed_reg <= seed_mag_w + 32'd1;
        end
        if (cmd.seed_load) begin
            m_reg    <= cxsr_pkg::MULT_INIT + {iseed_reg[30:0], 1'b0};
            prod_reg <= iseed_reg * cxsr_pkg::SEED_MULT;
        end else if (cmd.m_step) begin
            m_reg <= m_reg * cxsr_pkg::MULT_STEP;
        end
        if (cmd.r_load) begin
            r_reg <= rem_w;
        end
    end

    // fill index walks the long table then the short table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_idx_reg   <= '0;
            fill_short_reg <= 1'b0;
        end else if (cmd.fill_start) begin
            fill_idx_reg   <= '0;
            fill_short_reg <= 1'b0;
        end else if (cmd.fill_wr) begin
            if (!fill_short_reg && fill_idx_reg == cxsr_pkg::FILL_AW'(cxsr_pkg::LONG_LEN - 1)) begin
                fill_idx_reg   <= '0;
                fill_short_reg <= 1'b1;
            end else if (status.fill_last) begin
                fill_idx_reg   <= '0;
                fill_short_reg <= 1'b0;
            end else begin
                fill_idx_reg <= fill_idx_reg + 1'b1;
            end
        end
    end

    assign status.fill_last = fill_short_reg &&
                              (fill_idx_reg == cxsr_pkg::FILL_AW'(cxsr_pkg::SHORT_LEN - 1));

    // circular head and tap pointers
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.fill_start) begin
            long_head_reg  <= '0;
            long_tap_reg   <= cxsr_pkg::LONG_AW'(cxsr_pkg::LONG_TAP_RST);
            short_head_reg <= '0;
            short_tap_reg  <= cxsr_pkg::SHORT_AW'(cxsr_pkg::SHORT_TAP_RST);
        end else if (cmd.adv_wr) begin
            long_head_reg  <= (long_head_reg == cxsr_pkg::LONG_AW'(cxsr_pkg::LONG_LEN - 1))
                            ? '0 : long_head_reg + 1'b1;
            long_tap_reg   <= (long_tap_reg == cxsr_pkg::LONG_AW'(cxsr_pkg::LONG_LEN - 1))
                            ? '0 : long_tap_reg + 1'b1;
            short_head_reg <= (short_head_reg == cxsr_pkg::SHORT_AW'(cxsr_pkg::SHORT_LEN - 1))
                            ? '0 : short_head_reg + 1'b1;
            short_tap_reg  <= (short_tap_reg == cxsr_pkg::SHORT_AW'(cxsr_pkg::SHORT_LEN - 1))
                            ? '0 : short_tap_reg + 1'b1;
        end
    end

    // new words from head and tap reads
    assign long_new_w  = long_rd_a_reg ^ long_rd_b_reg;
    assign short_new_w = short_rd_a_reg ^ short_rd_b_reg;

    // write port selection: seeding fill or generator write-back
    assign long_we_w     = (cmd.fill_wr && !fill_short_reg) || cmd.adv_wr;
    assign short_we_w    = (cmd.fill_wr && fill_short_reg) || cmd.adv_wr;
    assign long_waddr_w  = cmd.fill_wr ? fill_idx_reg[cxsr_pkg::LONG_AW-1:0] : long_head_reg;
    assign short_waddr_w = cmd.fill_wr ? fill_idx_reg[cxsr_pkg::SHORT_AW-1:0] : short_head_reg;
    assign long_wdata_w  = cmd.fill_wr ? fill_word_w : long_new_w;
    assign short_wdata_w = cmd.fill_wr ? fill_word_w : short_new_w;

    // long table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (long_we_w) begin
            long_mem[long_waddr_w] <= long_wdata_w;
        end
        long_rd_a_reg <= long_mem[long_head_reg];
        long_rd_b_reg <= long_mem[long_tap_reg];
    end

    // short table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (short_we_w) begin
            short_mem[short_waddr_w] <= short_wdata_w;
        end
        short_rd_a_reg <= short_mem[short_head_reg];
        short_rd_b_reg <= short_mem[short_tap_reg];
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= long_new_w ^ short_new_w;
        end
    end

    assign out_data = out_reg;

endmodule

### design/cxsr_ctrl.sv
// cxsr_ctrl: sequencer for seeding fill, batch skip, table advance and output handshake
// depends on cxsr_pkg
module cxsr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   draw,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  cxsr_pkg::cxsr_status_t status,
    output cxsr_pkg::cxsr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MAG,
        ST_SEED_MUL,
        ST_SEED_FEED,
        ST_SEED_Q,
        ST_SEED_SUB,
        ST_SEED_UPD,
        ST_FILL_MUL,
        ST_FILL_Q,
        ST_FILL_SUB,
        ST_FILL_UPD,
        ST_FILL_WR,
        ST_ADV_RD,
        ST_ADV_WR
    } state_t;

    state_t                       state_reg, state_next;
    logic                         seeded_reg, seeded_next;
    logic                         skip_reg, skip_next;
    logic [cxsr_pkg::BATCH_W-1:0] batch_reg, batch_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free_w;

    localparam logic [cxsr_pkg::BATCH_W-1:0] BATCH_FULL = cxsr_pkg::BATCH_W'(cxsr_pkg::BATCH_SIZE);
    localparam logic [cxsr_pkg::BATCH_W-1:0] BATCH_LAST =
        cxsr_pkg::BATCH_W'(cxsr_pkg::BATCH_SIZE - 1);

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign out_free_w = !out_valid_reg || m_tready;

    // next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        skip_next      = skip_reg;
        batch_next     = batch_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && draw) begin
                    if (!seeded_reg) begin
                        state_next = ST_SEED_MAG;
                    end else begin
                        skip_next  = (batch_reg == BATCH_LAST);
                        batch_next = (batch_reg == BATCH_LAST || batch_reg >= BATCH_FULL)
                                   ? cxsr_pkg::BATCH_W'(1) : batch_reg + 1'b1;
                        state_next = ST_ADV_RD;
                    end
                end
            end
            ST_SEED_MAG: begin
                cmd.seed_prep  = 1'b1;
                cmd.fill_start = 1'b1;
                state_next     = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                cmd.seed_load = 1'b1;
                state_next    = ST_SEED_FEED;
            end
            ST_SEED_FEED: begin
                cmd.rem_from_seed = 1'b1;
                state_next        = ST_SEED_Q;
            end
            ST_SEED_Q: begin
                state_next = ST_SEED_SUB;
            end
            ST_SEED_SUB: begin
                state_next = ST_SEED_UPD;
            end
            ST_SEED_UPD: begin
                cmd.r_load = 1'b1;
                state_next = ST_FILL_MUL;
            end
            ST_FILL_MUL: begin
                cmd.m_step = 1'b1;
                state_next = ST_FILL_Q;
            end
            ST_FILL_Q: begin
                state_next = ST_FILL_SUB;
            end
            ST_FILL_SUB: begin
                state_next = ST_FILL_UPD;
            end
            ST_FILL_UPD: begin
                cmd.r_load = 1'b1;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last) begin
                    // fill done: batch restarts at one, no skip on this draw
                    seeded_next = 1'b1;
                    skip_next   = 1'b0;
                    batch_next  = cxsr_pkg::BATCH_W'(1);
                    state_next  = ST_ADV_RD;
                end else begin
                    state_next = ST_FILL_MUL;
                end
            end
            ST_ADV_RD: begin
                // registered table reads settle; unless the word is skipped, hold until the output slot frees
                if (skip_reg || out_free_w) begin
                    state_next = ST_ADV_WR;
                end
            end
            ST_ADV_WR: begin
                cmd.adv_wr   = 1'b1;
                cmd.out_load = !skip_reg;
                skip_next    = 1'b0;
                state_next   = skip_reg ? ST_ADV_RD : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output slot
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end

        // a new seed schedules a refill
        if (cfg_we) begin
            seeded_next = 1'b0;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            skip_reg      <= 1'b0;
            batch_reg     <= BATCH_FULL;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            skip_reg      <= skip_next;
            batch_reg     <= batch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/combined_xor_shift_register_rng.sv
// Sequence: an accepted draw passes ADV_RD then ADV_WR, which loads its word; on a batch
// skip a first ADV_RD/ADV_WR pass discards a word; the first draw after reset or a seed
// write first runs the table fill, a five-step remainder loop for each table word.
// Draws are taken only in idle; an unskipped ADV_RD waits while the output slot is full.
// Reset (synchronous, aresetn low): control, pointers and seed cleared; tables are not
// cleared and are filled from the seed on the first draw.
module combined_xor_shift_register_rng (
    input  logic        aclk,
    input  logic        aresetn,
    // draw requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] draw, [7:1] zero
    // random words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] random_word
    // seed register
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata  // [31:0] seed_value
);

    cxsr_pkg::cxsr_cmd_t    cmd;
    cxsr_pkg::cxsr_status_t status;

    // sequencer
    cxsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .draw     (s_tdata[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, sequences and output word
    cxsr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

### bench/combined_xor_shift_register_rng_tb.sv
`timescale 1ns / 1ps
// bench for the combined lagged-fibonacci word generator: drives draw and seed transactions and
// checks every returned word against a scoreboard that keeps its own copy of both tables
// depends on cxsr_pkg and combined_xor_shift_register_rng
module combined_xor_shift_register_rng_tb;

    localparam bit     DRAW_NONE    = 1'b0;
    localparam bit     DRAW_WORD    = 1'b1;
    localparam int     TAIL_CYCLES  = 8;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RANDOM_DRAWS = 480;
    localparam int     MAX_PRINTED  = 40;
    localparam longint CYCLE_LIMIT  = 4000000;

    // scoreboard: predicts each word from its own tables and checks results in order
    class word_scoreboard;
        bit [31:0] seed;
        bit        seeded;
        bit [31:0] long_words [cxsr_pkg::LONG_LEN];
        bit [31:0] short_words [cxsr_pkg::SHORT_LEN];
        int        long_head;
        int        long_tap;
        int        short_head;
        int        short_tap;
        int        batch_pos;
        bit [31:0] words_due [$];
        int        error_count;
        int        words_checked;

        function new();
            seed          = '0;
            seeded        = 1'b0;
            batch_pos     = cxsr_pkg::BATCH_SIZE;
            error_count   = 0;
            words_checked = 0;
        endfunction

        function void load_seed(input bit [31:0] value);
            seed   = value;
            seeded = 1'b0;
        endfunction

        // seeding fill: wrapping multiplicative sequence plus truncating remainder sequence
        function void fill_tables();
            bit [31:0] mag;
            bit [31:0] iseed;
            bit [31:0] prod;
            bit [31:0] mult_seq;
            longint    rem_seq;
            longint    term;
            longint    divisor;
            longint    rem_mult;
            divisor  = cxsr_pkg::MOD_DIV;
            rem_mult = cxsr_pkg::MOD_STEP;
            mag      = seed[31] ? -seed : seed;
            iseed    = mag + 1;
            mult_seq = cxsr_pkg::MULT_INIT + 2 * iseed;
            prod     = cxsr_pkg::SEED_MULT * iseed;
            rem_seq  = longint'($signed(prod)) % divisor;
            for (int i = 0; i < cxsr_pkg::LONG_LEN; i++) begin
                mult_seq      = mult_seq * cxsr_pkg::MULT_STEP;
                rem_seq       = (rem_seq * rem_mult) % divisor;
                term          = rem_seq * longint'(cxsr_pkg::LONG_FACTOR);
                long_words[i] = mult_seq + term[31:0];
            end
            for (int i = 0; i < cxsr_pkg::SHORT_LEN; i++) begin
                mult_seq       = mult_seq * cxsr_pkg::MULT_STEP;
                rem_seq        = (rem_seq * rem_mult) % divisor;
                term           = rem_seq * longint'(cxsr_pkg::SHORT_FACTOR);
                short_words[i] = mult_seq + term[31:0];
            end
            long_head  = 0;
            long_tap   = cxsr_pkg::LONG_TAP % cxsr_pkg::LONG_LEN;
            short_head = 0;
            short_tap  = cxsr_pkg::SHORT_TAP % cxsr_pkg::SHORT_LEN;
            batch_pos  = cxsr_pkg::BATCH_SIZE;
            seeded     = 1'b1;
        endfunction

        // one step of both tables, the word is the xor of the two new entries
        function bit [31:0] next_word();
            bit [31:0] l;
            bit [31:0] s;
            l = long_words[long_head] ^ long_words[long_tap];
            s = short_words[short_head] ^ short_words[short_tap];
            long_words[long_head]   = l;
            short_words[short_head] = s;
            long_head  = (long_head + 1) % cxsr_pkg::LONG_LEN;
            long_tap   = (long_tap + 1) % cxsr_pkg::LONG_LEN;
            short_head = (short_head + 1) % cxsr_pkg::SHORT_LEN;
            short_tap  = (short_tap + 1) % cxsr_pkg::SHORT_LEN;
            return l ^ s;
        endfunction

        function void note_draw(input bit draw_bit);
            bit [31:0] discarded;
            if (draw_bit == DRAW_NONE)
                return;
            if (!seeded)
                fill_tables();
            // batch boundary: one word is thrown away before the returned one
            if (batch_pos == cxsr_pkg::BATCH_SIZE - 1) begin
                discarded = next_word();
                batch_pos = 1;
            end else if (batch_pos >= cxsr_pkg::BATCH_SIZE) begin
                batch_pos = 1;
            end else begin
                batch_pos = batch_pos + 1;
            end
            words_due.push_back(next_word());
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        task report(input string msg);
            if (error_count < MAX_PRINTED)
                $display("MISMATCH: %s", msg);
            error_count++;
        endtask

        task check_word(input logic [31:0] got);
            bit [31:0] want;
            words_checked++;
            if (words_due.size() == 0) begin
                report($sformatf("word %08h arrived with no draw waiting", got));
            end else begin
                want = words_due.pop_front();
                if (want !== got)
                    report($sformatf("word %0d: got %08h, expected %08h",
                                     words_checked, got, want));
            end
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    word_scoreboard sb;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_reqs     = 0;
    int     hold_seen     = 0;
    int     hold_left     = 0;
    int     draws_sent    = 0;
    int     nulls_sent    = 0;
    int     seeds_written = 0;
    longint cycles        = 0;

    combined_xor_shift_register_rng DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // check every word transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // offer one draw transaction, with random idle cycles ahead of it
    task automatic send_draw(input bit draw_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, draw_bit};
        do @(posedge aclk); while (!s_tready);
        sb.note_draw(draw_bit);
        if (draw_bit == DRAW_WORD)
            draws_sent++;
        else
            nulls_sent++;
    endtask

    // stop offering and wait until every due word has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input bit [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.load_seed(value);
        cfg_we <= 1'b0;
        @(posedge aclk);
        seeds_written++;
    endtask

    // mostly draws with some empty requests, optional pause half way
    task automatic run_random(input int draw_target, input bit with_pause);
        int drawn;
        bit draw_bit;
        drawn = 0;
        while (drawn < draw_target) begin
            draw_bit = ($urandom_range(99) < 85) ? DRAW_WORD : DRAW_NONE;
            send_draw(draw_bit);
            if (draw_bit == DRAW_WORD) begin
                drawn++;
                if (with_pause && drawn == draw_target / 2)
                    settle();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles 35 %, receiver 75 % through the directed seeds and the first random run
        send_idle_pct = 35;
        recv_idle_pct = 75;

        // reset seed of zero, empty requests around the first fill
        send_draw(DRAW_NONE);
        send_draw(DRAW_WORD);
        send_draw(DRAW_NONE);
        repeat (3) send_draw(DRAW_WORD);
        settle();

        // most negative seed
        write_seed(32'h8000_0000);
        repeat (4) send_draw(DRAW_WORD);
        settle();

        // largest positive seed
        write_seed(32'h7FFF_FFFF);
        send_draw(DRAW_WORD);
        send_draw(DRAW_NONE);
        repeat (2) send_draw(DRAW_WORD);
        settle();

        // minus one, empty request first must not start the fill
        write_seed(32'hFFFF_FFFF);
        send_draw(DRAW_NONE);
        repeat (3) send_draw(DRAW_WORD);
        settle();

        // two writes before any draw, only the later zero seed counts
        write_seed($urandom());
        write_seed(32'h0);
        repeat (2) send_draw(DRAW_WORD);
        settle();

        // random run with one full drain half way
        write_seed($urandom());
        run_random(RANDOM_DRAWS, 1'b1);
        settle();

        // sender idles 75 %, receiver 35 %
        send_idle_pct = 75;
        recv_idle_pct = 35;
        write_seed($urandom());
        run_random(RANDOM_DRAWS, 1'b0);
        settle();

        // no idling; after the fill the receiver holds off while draws keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed($urandom());
        send_draw(DRAW_WORD);
        settle();
        hold_reqs++;
        run_random(RANDOM_DRAWS, 1'b0);
        settle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d words never arrived", sb.pending()));
        $display("covered %0d words checked from %0d draws over %0d seed writes",
                 sb.words_checked, draws_sent, seeds_written);
        $display("seeds at zero, both extremes, minus one and random; %0d empty requests, %s",
                 nulls_sent, "three idle mixes and a long output stall");
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
design/cxsr_pkg.sv
design/cxsr_rem.sv
design/cxsr_dp.sv
design/cxsr_ctrl.sv
design/combined_xor_shift_register_rng.sv
bench/combined_xor_shift_register_rng_tb.sv
